// ----- rtl/core/m3i_pkg.sv -----
// ----------------------------------------------------------------------------
// m3i_pkg: shared types and constants of the 3x3 matrix inverse
// Element width, derived word widths and the beat structs of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

package m3i_pkg;

	// Element width is fixed by the port structs.
	localparam int ELEMENT_WIDTH = 32;
	localparam int FRAC_BITS_DEF = 16;

	// Exact widths: element product, cofactor, determinant.
	localparam int PROD_W = 2 * ELEMENT_WIDTH;
	localparam int COF_W  = 2 * ELEMENT_WIDTH + 1;
	localparam int DET_W  = 3 * ELEMENT_WIDTH + 3;

	typedef logic signed [ELEMENT_WIDTH-1:0] elem_t;
	typedef logic signed [PROD_W-1:0]        prod_t;
	typedef logic signed [COF_W-1:0]         cof_t;
	typedef logic signed [DET_W-1:0]         det_t;

	typedef struct packed {
		elem_t a00;
		elem_t a01;
		elem_t a02;
		elem_t a10;
		elem_t a11;
		elem_t a12;
		elem_t a20;
		elem_t a21;
		elem_t a22;
	} mat_in_t;

	typedef struct packed {
		elem_t b00;
		elem_t b01;
		elem_t b02;
		elem_t b10;
		elem_t b11;
		elem_t b12;
		elem_t b20;
		elem_t b21;
		elem_t b22;
		logic  singular;
	} mat_out_t;

	// Determinant as the divider lanes see it.
	typedef struct packed {
		logic [DET_W-1:0] mag;
		logic             neg;
		logic             zero;
	} det_info_t;

	// Divider lane depth, and cycles from an accepted beat to the lane outputs.
	localparam int LANE_LAT = ELEMENT_WIDTH + 2;
	localparam int PIPE_LAT = 6 + LANE_LAT;

endpackage

`default_nettype wire

// ----- rtl/core/matrix3x3_inverse.sv -----
// ----------------------------------------------------------------------------
// matrix3x3_inverse: inverse of a signed fixed-point 3x3 matrix
// Adjugate over determinant, rounded to nearest and saturated per element.
// ----------------------------------------------------------------------------
//
//   channel   handshake        payload     direction
//   input     start / busy     a (9 x Q)   into the block
//   result    done (strobe)    b (9 x Q)   out of the block, plus singular
//
// The block takes one beat in every cycle; busy stays low. Each result
// passes through the cofactor, determinant, divider-lane and merge stages;
// the divider lanes resolve one quotient bit per stage. Reset clears only
// the valid chain and the done register, so no stray strobe appears.
// The receiver cannot stall; done is a single-cycle strobe per result beat.
//
`default_nettype none

module matrix3x3_inverse import m3i_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output logic         busy,
	input  wire mat_in_t a,
	output logic         done,
	output mat_out_t     b
);

	// The pipeline never holds off a beat.
	assign busy = 1'b0;

	// Front end: products and cofactors.
	cof_t  cof_s2 [9];
	elem_t col0_s2 [3];

	m3i_cofactor u_cof (
		.clk     (clk),
		.a       (a),
		.cof_s2  (cof_s2),
		.col0_s2 (col0_s2)
	);

	// Determinant, with the cofactors delayed to line up with it.
	cof_t      cof_s6 [9];
	det_info_t info_s6;

	m3i_det u_det (
		.clk     (clk),
		.cof_s2  (cof_s2),
		.col0_s2 (col0_s2),
		.cof_s6  (cof_s6),
		.info_s6 (info_s6)
	);

	// Nine divider lanes, one per adjugate element, all fed the same
	// determinant.
	elem_t lane_elem [9];

	for (genvar i = 0; i < 9; i++) begin : g_lane
		m3i_div_lane #(
			.FRAC_BITS (FRAC_BITS)
		) u_lane (
			.clk    (clk),
			.cof    (cof_s6[i]),
			.det    (info_s6),
			.elem_q (lane_elem[i])
		);
	end

	// The zero-determinant flag travels beside the lanes.
	logic zero_q [LANE_LAT];

	always_ff @(posedge clk) begin
		zero_q[0] <= info_s6.zero;
		for (int k = 1; k < LANE_LAT; k++) begin
			zero_q[k] <= zero_q[k-1];
		end
	end

	// The valid chain marks which pipeline slots carry a beat.
	logic [PIPE_LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[PIPE_LAT-2:0], start & ~busy};
		end
	end

	// Merge stage: a singular matrix forces every element to zero.
	logic     sing;
	mat_out_t b_q;
	logic     done_q;

	assign sing = zero_q[LANE_LAT-1];

	always_ff @(posedge clk) begin
		b_q.b00      <= sing ? '0 : lane_elem[0];
		b_q.b01      <= sing ? '0 : lane_elem[1];
		b_q.b02      <= sing ? '0 : lane_elem[2];
		b_q.b10      <= sing ? '0 : lane_elem[3];
		b_q.b11      <= sing ? '0 : lane_elem[4];
		b_q.b12      <= sing ? '0 : lane_elem[5];
		b_q.b20      <= sing ? '0 : lane_elem[6];
		b_q.b21      <= sing ? '0 : lane_elem[7];
		b_q.b22      <= sing ? '0 : lane_elem[8];
		b_q.singular <= sing;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_q[PIPE_LAT-1];
		end
	end

	assign done = done_q;
	assign b    = b_q;

endmodule

`default_nettype wire

// ----- rtl/core/m3i_cofactor.sv -----
// ----------------------------------------------------------------------------
// m3i_cofactor: element products and cofactors
// Eighteen element products in the first stage, nine cofactors in the second.
// ----------------------------------------------------------------------------
`default_nettype none

module m3i_cofactor import m3i_pkg::*; (
	input  wire logic    clk,
	input  wire mat_in_t a,
	output cof_t         cof_s2 [9],
	output elem_t        col0_s2 [3]
);

	// Operand pairs: cofactor k is prod[2k] - prod[2k+1].
	localparam logic [3:0] OP_A [18] = '{4'd4, 4'd7, 4'd7, 4'd1, 4'd1, 4'd4,
		4'd6, 4'd3, 4'd0, 4'd6, 4'd3, 4'd0, 4'd3, 4'd6, 4'd6, 4'd0, 4'd0, 4'd3};
	localparam logic [3:0] OP_B [18] = '{4'd8, 4'd5, 4'd2, 4'd8, 4'd5, 4'd2,
		4'd5, 4'd8, 4'd8, 4'd2, 4'd2, 4'd5, 4'd7, 4'd4, 4'd1, 4'd7, 4'd4, 4'd1};

	elem_t e [9];
	prod_t prod_s1 [18];
	elem_t col0_s1 [3];

	assign e[0] = a.a00;
	assign e[1] = a.a01;
	assign e[2] = a.a02;
	assign e[3] = a.a10;
	assign e[4] = a.a11;
	assign e[5] = a.a12;
	assign e[6] = a.a20;
	assign e[7] = a.a21;
	assign e[8] = a.a22;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 18; k++) begin
			prod_s1[k] <= PROD_W'(e[OP_A[k]]) * PROD_W'(e[OP_B[k]]);
		end
		col0_s1[0] <= e[0];
		col0_s1[1] <= e[3];
		col0_s1[2] <= e[6];
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++) begin
			cof_s2[k] <= COF_W'(prod_s1[2*k]) - COF_W'(prod_s1[2*k+1]);
		end
		col0_s2 <= col0_s1;
	end

endmodule

`default_nettype wire

// ----- rtl/core/m3i_det.sv -----
// ----------------------------------------------------------------------------
// m3i_det: determinant by expansion along the first column
// Split products, partial sums, total, then magnitude and sign of the total.
// ----------------------------------------------------------------------------
`default_nettype none

module m3i_det import m3i_pkg::*; (
	input  wire logic  clk,
	input  wire cof_t  cof_s2 [9],
	input  wire elem_t col0_s2 [3],
	output cof_t       cof_s6 [9],
	output det_info_t  info_s6
);

	localparam int PP_W = ELEMENT_WIDTH + ELEMENT_WIDTH + 1;
	localparam int HI_W = COF_W - ELEMENT_WIDTH;

	logic signed [PP_W-1:0] lo_s3 [3];
	logic signed [PP_W-1:0] hi_s3 [3];
	det_t term_s4 [3];
	det_t det_s5;
	cof_t cof_s3 [9];
	cof_t cof_s4 [9];
	cof_t cof_s5 [9];

	// Each element times cofactor product is cut into a low and a high half.
	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			lo_s3[j] <= PP_W'(col0_s2[j])
				* PP_W'($signed({1'b0, cof_s2[j][ELEMENT_WIDTH-1:0]}));
			hi_s3[j] <= PP_W'(col0_s2[j])
				* PP_W'($signed(cof_s2[j][COF_W-1 -: HI_W]));
		end
		cof_s3 <= cof_s2;
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			term_s4[j] <= DET_W'(lo_s3[j]) + (DET_W'(hi_s3[j]) <<< ELEMENT_WIDTH);
		end
		cof_s4 <= cof_s3;
	end

	always_ff @(posedge clk) begin
		det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
		cof_s5 <= cof_s4;
	end

	always_ff @(posedge clk) begin
		info_s6.zero <= (det_s5 == '0);
		info_s6.neg  <= det_s5[DET_W-1];
		info_s6.mag  <= det_s5[DET_W-1] ? $unsigned(-det_s5) : $unsigned(det_s5);
		cof_s6       <= cof_s5;
	end

endmodule

`default_nettype wire

// ----- rtl/core/m3i_div_lane.sv -----
// ----------------------------------------------------------------------------
// m3i_div_lane: one lane of rounded, saturating division
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module m3i_div_lane import m3i_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic      clk,
	input  wire cof_t      cof,
	input  wire det_info_t det,
	output elem_t          elem_q
);

	localparam int SH    = 2 * FRAC_BITS + 1;
	localparam int NW0   = (COF_W + SH > DET_W) ? COF_W + SH : DET_W;
	localparam int NW    = NW0 + 1;
	localparam int DSW   = DET_W + ELEMENT_WIDTH;
	localparam int UW    = (NW > DSW) ? NW : DSW;
	localparam int QS    = ELEMENT_WIDTH - 1;
	localparam elem_t EMAX = {1'b0, {(ELEMENT_WIDTH-1){1'b1}}};
	localparam elem_t EMIN = {1'b1, {(ELEMENT_WIDTH-1){1'b0}}};

	logic [COF_W-1:0] cmag;
	logic [UW-1:0]    n_s1;
	logic [UW-1:0]    d_s1;
	logic             neg_s1;

	logic [UW-1:0] rem_sk [QS+1];
	logic [UW-1:0] dv_sk [QS+1];
	logic [QS-1:0] quo_sk [QS+1];
	logic          neg_sk [QS+1];
	logic          sat_sk [QS+1];

	assign cmag = cof[COF_W-1] ? $unsigned(-cof) : $unsigned(cof);

	// Rounded quotient is floor(((|N| << SH) + |D|) / (2|D|)).
	always_ff @(posedge clk) begin
		n_s1   <= (UW'(cmag) << SH) + UW'(det.mag);
		d_s1   <= UW'(det.mag) << 1;
		neg_s1 <= cof[COF_W-1] ^ det.neg;
	end

	always_ff @(posedge clk) begin
		rem_sk[0] <= n_s1;
		dv_sk[0]  <= d_s1;
		quo_sk[0] <= '0;
		neg_sk[0] <= neg_s1;
		sat_sk[0] <= (n_s1 >= (d_s1 << QS));
	end

	for (genvar k = 1; k <= QS; k++) begin : g_step
		logic [UW-1:0] trial;
		assign trial = dv_sk[k-1] << (QS - k);
		always_ff @(posedge clk) begin
			dv_sk[k]  <= dv_sk[k-1];
			neg_sk[k] <= neg_sk[k-1];
			sat_sk[k] <= sat_sk[k-1];
			if (rem_sk[k-1] >= trial) begin
				rem_sk[k] <= rem_sk[k-1] - trial;
				quo_sk[k] <= quo_sk[k-1] | (QS'(1) << (QS - k));
			end else begin
				rem_sk[k] <= rem_sk[k-1];
				quo_sk[k] <= quo_sk[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sat_sk[QS]) begin
			elem_q <= neg_sk[QS] ? EMIN : EMAX;
		end else if (neg_sk[QS]) begin
			elem_q <= -$signed({1'b0, quo_sk[QS]});
		end else begin
			elem_q <= $signed({1'b0, quo_sk[QS]});
		end
	end

	// rem_sk[QS] holds the final remainder and is not needed further.
	logic unused_rem;
	assign unused_rem = ^rem_sk[QS];

endmodule

`default_nettype wire

// ----- rtl/core/m3i_checker.sv -----
// ----------------------------------------------------------------------------
// m3i_checker: port-level checks of the matrix inverse
// Watches the handshake and the result beats, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module m3i_checker import m3i_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     start,
	input wire logic     busy,
	input wire mat_in_t  a,
	input wire logic     done,
	input wire mat_out_t b
);

	localparam int RES_LAT = PIPE_LAT + 1;

	// The block never refuses a beat.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy asserted");

	// Every result beat goes back to an input beat a fixed time earlier.
	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, RES_LAT))
		else $error("result beat without matching input beat");

	// A singular result carries only zero elements.
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && b.singular) |-> (b.b00 == '0 && b.b01 == '0 && b.b02 == '0
			&& b.b10 == '0 && b.b11 == '0 && b.b12 == '0
			&& b.b20 == '0 && b.b21 == '0 && b.b22 == '0))
		else $error("singular result with nonzero element");

	logic unused_in;
	assign unused_in = ^a;

endmodule

bind matrix3x3_inverse m3i_checker u_m3i_checker (.*);

`default_nettype wire
